>>> src/empq_pkg.sv
package empq_pkg;

  // Distance scaling: pulse_us * 1124 >> 8 gives 1/256 cm
  localparam logic [10:0] DIST_MUL   = 11'd1124;
  localparam int          DIST_SHIFT = 8;
  localparam int          PROD_W     = 25;
  localparam int          DIST_W     = 15;
  localparam int          PULSE_W    = 14;
  localparam int          RND_W      = 4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TIMEOUT     = 3'd0,
    REG_MIN_DIST    = 3'd1,
    REG_MAX_DIST    = 3'd2,
    REG_DETECT_DIST = 3'd3,
    REG_RELEASE_DIST = 3'd4,
    REG_DETECT_RNDS = 3'd5,
    REG_RELEASE_RNDS = 3'd6,
    REG_INVALID_LIM = 3'd7
  } cfg_reg_e;

  // Reset values of the registers
  localparam logic [PULSE_W-1:0] TIMEOUT_RST     = 14'd12000;
  localparam logic [DIST_W-1:0]  MIN_DIST_RST    = 15'd256;
  localparam logic [DIST_W-1:0]  MAX_DIST_RST    = 15'd20480;
  localparam logic [DIST_W-1:0]  DETECT_DIST_RST = 15'd1024;
  localparam logic [DIST_W-1:0]  RELEASE_DIST_RST = 15'd1024;
  localparam logic [RND_W-1:0]   DETECT_RNDS_RST = 4'd2;
  localparam logic [RND_W-1:0]   RELEASE_RNDS_RST = 4'd2;
  localparam logic [RND_W-1:0]   INVALID_LIM_RST = 4'd5;

  // Summary of a finished round, handed to the debouncer
  typedef struct packed {
    logic              done;
    logic              any_valid;
    logic [DIST_W-1:0] median;
  } round_sum_t;

  // Debouncer settings
  typedef struct packed {
    logic [DIST_W-1:0] detect_dist;
    logic [DIST_W-1:0] release_dist;
    logic [RND_W-1:0]  detect_rounds;
    logic [RND_W-1:0]  release_rounds;
    logic [RND_W-1:0]  invalid_limit;
  } deb_cfg_t;

endpackage

>>> src/echo_median_presence_qualifier.sv
// Echo median presence qualifier.
// Input channel (in_valid / in_stall): one echo word per measurement,
// echo_seen and pulse_us. Output channel (out_valid / out_stall): one
// result word per round of SAMPLES_PER_ROUND input words, carrying the
// debounced presence flag, the median distance and the valid sample count.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// at the clock edge. Users write only while the block is idle; unchecked.
// Timing: an input word is registered in the input register on acceptance;
// the result word of a round is captured in the result register when the
// round's last word leaves the input register. Throughput is one input
// word per cycle unless a round end waits on a held result, set by the
// single input register feeding the qualify, median and debounce logic.
// Reset (synchronous, active high) restores register defaults, empties
// the pipeline and clears round position and debounce counters.
// A stalled result word holds; input words that finish no round keep
// flowing, and only a round end waiting on a held result stalls the input.
module echo_median_presence_qualifier
  import empq_pkg::*;
#(
  parameter int SAMPLES_PER_ROUND = 3
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               echo_seen,
  input  logic [PULSE_W-1:0] pulse_us,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               vehicle_present,
  output logic               reading_valid,
  output logic [DIST_W-1:0]  distance_q8,
  output logic [2:0]         valid_samples,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [DIST_W-1:0]  cfg_data
);

  localparam int CW = $clog2(SAMPLES_PER_ROUND + 1);

  // Configuration registers
  logic [PULSE_W-1:0] timeout_us;
  logic [DIST_W-1:0]  min_distance_q8, max_distance_q8;
  deb_cfg_t           deb_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us             <= TIMEOUT_RST;
      min_distance_q8        <= MIN_DIST_RST;
      max_distance_q8        <= MAX_DIST_RST;
      deb_cfg.detect_dist    <= DETECT_DIST_RST;
      deb_cfg.release_dist   <= RELEASE_DIST_RST;
      deb_cfg.detect_rounds  <= DETECT_RNDS_RST;
      deb_cfg.release_rounds <= RELEASE_RNDS_RST;
      deb_cfg.invalid_limit  <= INVALID_LIM_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_TIMEOUT:      timeout_us             <= cfg_data[PULSE_W-1:0];
        REG_MIN_DIST:     min_distance_q8        <= cfg_data;
        REG_MAX_DIST:     max_distance_q8        <= cfg_data;
        REG_DETECT_DIST:  deb_cfg.detect_dist    <= cfg_data;
        REG_RELEASE_DIST: deb_cfg.release_dist   <= cfg_data;
        REG_DETECT_RNDS:  deb_cfg.detect_rounds  <= cfg_data[RND_W-1:0];
        REG_RELEASE_RNDS: deb_cfg.release_rounds <= cfg_data[RND_W-1:0];
        REG_INVALID_LIM:  deb_cfg.invalid_limit  <= cfg_data[RND_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic               s1_valid;
  logic               s1_seen;
  logic [PULSE_W-1:0] s1_pulse;
  logic               s1_fire, in_accept;

  // Round tracking and sample store
  logic [CW-1:0]     round_position, valid_in_round;
  logic [DIST_W-1:0] sample_store [SAMPLES_PER_ROUND];
  logic [DIST_W-1:0] cand [SAMPLES_PER_ROUND];
  logic [CW-1:0]     n_total;
  logic              round_end, store_wr;
  logic [DIST_W-1:0] sample_dist, median;
  logic              sample_ok;
  round_sum_t        round;
  logic              present_next;

  assign round_end = (round_position == CW'(SAMPLES_PER_ROUND - 1));
  assign s1_fire   = s1_valid && (!round_end || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_seen  <= echo_seen;
      s1_pulse <= pulse_us;
    end
  end

  empq_qualify u_qualify (
    .echo_seen       (s1_seen),
    .pulse_us        (s1_pulse),
    .timeout_us      (timeout_us),
    .min_distance_q8 (min_distance_q8),
    .max_distance_q8 (max_distance_q8),
    .sample_dist     (sample_dist),
    .sample_ok       (sample_ok)
  );

  assign store_wr = s1_fire && sample_ok && (valid_in_round < CW'(SAMPLES_PER_ROUND));
  assign n_total  = valid_in_round + CW'(store_wr);

  // Store view including the sample being written this cycle
  always_comb begin
    for (int i = 0; i < SAMPLES_PER_ROUND; i++) begin
      cand[i] = (store_wr && (valid_in_round == CW'(i))) ? sample_dist : sample_store[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SAMPLES_PER_ROUND; i++) begin
      if (store_wr && (valid_in_round == CW'(i))) begin
        sample_store[i] <= sample_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_position <= '0;
      valid_in_round <= '0;
    end else if (s1_fire) begin
      round_position <= round_end ? '0 : round_position + CW'(1);
      valid_in_round <= round_end ? '0 : n_total;
    end
  end

  empq_median #(
    .N  (SAMPLES_PER_ROUND),
    .CW (CW)
  ) u_median (
    .vals   (cand),
    .count  (n_total),
    .median (median)
  );

  assign round.done      = s1_fire && round_end;
  assign round.any_valid = (n_total != '0);
  assign round.median    = median;

  empq_debounce u_debounce (
    .clk          (clk),
    .rst          (rst),
    .round        (round),
    .cfg          (deb_cfg),
    .present_next (present_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (round.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (round.done) begin
      vehicle_present <= present_next;
      reading_valid   <= round.any_valid;
      distance_q8     <= median;
      valid_samples   <= 3'(n_total);
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    round_position < CW'(SAMPLES_PER_ROUND))
    else $error("round position out of range");

  a_valid_le_pos: assert property (@(posedge clk) disable iff (rst)
    valid_in_round <= round_position)
    else $error("more valid samples than items in round");

  a_result_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((reading_valid == (valid_samples != 3'd0)) &&
                   (reading_valid || (distance_q8 == '0))))
    else $error("result fields inconsistent");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall && round_end))
    else $error("input stalled without a held result");
`endif

endmodule

>>> src/empq_qualify.sv
module empq_qualify
  import empq_pkg::*;
(
  input  logic               echo_seen,
  input  logic [PULSE_W-1:0] pulse_us,
  input  logic [PULSE_W-1:0] timeout_us,
  input  logic [DIST_W-1:0]  min_distance_q8,
  input  logic [DIST_W-1:0]  max_distance_q8,
  output logic [DIST_W-1:0]  sample_dist,
  output logic               sample_ok
);

  logic [PROD_W-1:0]            prod;
  logic [PROD_W-DIST_SHIFT-1:0] dist_full;

  // Scale width to distance; full width kept for the range check
  assign prod        = PROD_W'(pulse_us) * PROD_W'(DIST_MUL);
  assign dist_full   = prod[PROD_W-1:DIST_SHIFT];
  assign sample_dist = dist_full[DIST_W-1:0];

  assign sample_ok = echo_seen && (pulse_us != '0) && (pulse_us <= timeout_us) &&
                     (dist_full >= (PROD_W-DIST_SHIFT)'(min_distance_q8)) &&
                     (dist_full <= (PROD_W-DIST_SHIFT)'(max_distance_q8));

endmodule

>>> src/empq_median.sv
module empq_median
  import empq_pkg::*;
#(
  parameter int N  = 3,
  parameter int CW = 2
) (
  input  logic [DIST_W-1:0] vals [N],
  input  logic [CW-1:0]     count,
  output logic [DIST_W-1:0] median
);

  logic [CW-1:0] rank [N];
  logic [CW-1:0] target;

  // Rank of each sample among the first count entries; ties broken by position
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < N; j++) begin
        if ((j != i) && (CW'(j) < count) &&
            ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)))) begin
          rank[i] = rank[i] + CW'(1);
        end
      end
    end
  end

  // Upper middle rank; exactly one live entry matches when count is nonzero
  assign target = count >> 1;

  always_comb begin
    median = '0;
    for (int i = 0; i < N; i++) begin
      if ((CW'(i) < count) && (rank[i] == target)) begin
        median = median | vals[i];
      end
    end
  end

endmodule

>>> src/empq_debounce.sv
module empq_debounce
  import empq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  round_sum_t round,
  input  deb_cfg_t   cfg,
  output logic       present_next
);

  logic [RND_W-1:0] detect_count, detect_count_next;
  logic [RND_W-1:0] release_count, release_count_next;
  logic [RND_W-1:0] invalid_count, invalid_count_next;
  logic             present_flag, present_flag_next;
  logic [RND_W-1:0] det_inc, rel_inc, inv_inc;

  assign det_inc = detect_count + RND_W'(1);
  assign rel_inc = release_count + RND_W'(1);
  assign inv_inc = invalid_count + RND_W'(1);

  // Counted detect/release with an invalid-round limit
  always_comb begin
    detect_count_next  = detect_count;
    release_count_next = release_count;
    invalid_count_next = invalid_count;
    present_flag_next  = present_flag;
    if (round.done) begin
      if (round.any_valid) begin
        invalid_count_next = '0;
        if (!present_flag) begin
          release_count_next = '0;
          if (round.median < cfg.detect_dist) begin
            if (det_inc >= cfg.detect_rounds) begin
              present_flag_next = 1'b1;
              detect_count_next = '0;
            end else begin
              detect_count_next = det_inc;
            end
          end else begin
            detect_count_next = '0;
          end
        end else begin
          detect_count_next = '0;
          if (round.median >= cfg.release_dist) begin
            if (rel_inc >= cfg.release_rounds) begin
              present_flag_next  = 1'b0;
              release_count_next = '0;
            end else begin
              release_count_next = rel_inc;
            end
          end else begin
            release_count_next = '0;
          end
        end
      end else begin
        detect_count_next = '0;
        if (inv_inc >= cfg.invalid_limit) begin
          invalid_count_next = cfg.invalid_limit;
          release_count_next = '0;
          present_flag_next  = 1'b0;
        end else begin
          invalid_count_next = inv_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_count  <= '0;
      release_count <= '0;
      invalid_count <= '0;
      present_flag  <= 1'b0;
    end else begin
      detect_count  <= detect_count_next;
      release_count <= release_count_next;
      invalid_count <= invalid_count_next;
      present_flag  <= present_flag_next;
    end
  end

  assign present_next = present_flag_next;

endmodule

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import empq_pkg::*;

  localparam int ROUND       = 3;     // echo words per round
  localparam int IDLE_LIMIT  = 4000;  // cycles with no word moving before giving up
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int SETTLE      = 4;     // cycles for the input register to empty
  localparam int TAIL        = 8;
  localparam int MAX_PRINTS  = 100;

  // One round result word
  typedef struct packed {
    logic              present;
    logic              rvalid;
    logic [DIST_W-1:0] dist_q8;
    logic [2:0]        nsamp;
  } round_word_t;

  localparam round_word_t BLANK_ROUND = '0;

  // Directed stimulus row; want is used only when typed is set
  typedef struct packed {
    logic               seen;
    logic [PULSE_W-1:0] pulse;
    logic               typed;
    round_word_t        want;
  } dir_row_t;

  // Settings and traffic shape of one random phase
  typedef struct packed {
    logic               rnd;
    logic [PULSE_W-1:0] tmo;
    logic [DIST_W-1:0]  dmin;
    logic [DIST_W-1:0]  dmax;
    logic [DIST_W-1:0]  ddet;
    logic [DIST_W-1:0]  drel;
    logic [RND_W-1:0]   nd;
    logic [RND_W-1:0]   nr;
    logic [RND_W-1:0]   nl;
    logic [6:0]         tx;
    logic [6:0]         rx;
    logic [7:0]         n;
    logic               hold;
    logic               pause;
  } phase_t;

  // Reset settings: 12000 us, 256..20480, near below 1024, far from 1024, 2/2/5 rounds
  localparam dir_row_t DIR_ROWS [24] = '{
    // all invalid: no echo, no echo at full width, zero width
    '{1'b0, 14'd0,     1'b0, BLANK_ROUND},
    '{1'b0, 14'd16383, 1'b0, BLANK_ROUND},
    '{1'b1, 14'd0,     1'b1, BLANK_ROUND},
    // all invalid: over timeout, just under min distance, no echo
    '{1'b1, 14'd16383, 1'b0, BLANK_ROUND},
    '{1'b1, 14'd58,    1'b0, BLANK_ROUND},
    '{1'b0, 14'd100,   1'b1, BLANK_ROUND},
    // three valid at min, max and just near; median 1023 counts once
    '{1'b1, 14'd59,    1'b0, BLANK_ROUND},
    '{1'b1, 14'd4664,  1'b0, BLANK_ROUND},
    '{1'b1, 14'd233,   1'b1, '{1'b0, 1'b1, 15'd1023, 3'd3}},
    // one valid near sample sets presence
    '{1'b1, 14'd100,   1'b0, BLANK_ROUND},
    '{1'b1, 14'd4665,  1'b0, BLANK_ROUND},
    '{1'b0, 14'd5,     1'b0, BLANK_ROUND},
    // two valid far samples: upper middle taken
    '{1'b1, 14'd234,   1'b0, BLANK_ROUND},
    '{1'b1, 14'd1000,  1'b0, BLANK_ROUND},
    '{1'b1, 14'd50,    1'b0, BLANK_ROUND},
    // invalid round below the limit keeps presence
    '{1'b0, 14'd12000, 1'b0, BLANK_ROUND},
    '{1'b1, 14'd0,     1'b0, BLANK_ROUND},
    '{1'b0, 14'd1,     1'b0, BLANK_ROUND},
    // second far round clears presence
    '{1'b1, 14'd300,   1'b0, BLANK_ROUND},
    '{1'b1, 14'd400,   1'b0, BLANK_ROUND},
    '{1'b1, 14'd500,   1'b0, BLANK_ROUND},
    // invalid: too close, at timeout but too far, just over timeout
    '{1'b1, 14'd1,     1'b0, BLANK_ROUND},
    '{1'b1, 14'd12000, 1'b0, BLANK_ROUND},
    '{1'b1, 14'd12001, 1'b1, BLANK_ROUND}
  };

  localparam phase_t PHASES [10] = '{
    '{1'b0, 14'd12000, 15'd256,   15'd20480, 15'd1024,  15'd1024,  4'd2,  4'd2,  4'd5,
      7'd0,  7'd0,  8'd60, 1'b1, 1'b0},
    '{1'b0, 14'd16383, 15'd0,     15'd32767, 15'd16000, 15'd16000, 4'd1,  4'd1,  4'd1,
      7'd64, 7'd0,  8'd70, 1'b0, 1'b1},
    '{1'b0, 14'd16383, 15'd0,     15'd32767, 15'd32767, 15'd0,     4'd15, 4'd15, 4'd15,
      7'd0,  7'd64, 8'd60, 1'b0, 1'b0},
    '{1'b0, 14'd1,     15'd0,     15'd32767, 15'd0,     15'd0,     4'd1,  4'd1,  4'd1,
      7'd23, 7'd23, 8'd30, 1'b0, 1'b0},
    // min above max: nothing is ever valid
    '{1'b0, 14'd7000,  15'd20000, 15'd1000,  15'd2048,  15'd4096,  4'd3,  4'd2,  4'd2,
      7'd23, 7'd23, 8'd30, 1'b0, 1'b0},
    // zero round counts: met at once, invalid counter pinned at zero
    '{1'b0, 14'd12000, 15'd256,   15'd20480, 15'd3000,  15'd5000,  4'd0,  4'd0,  4'd0,
      7'd0,  7'd0,  8'd70, 1'b0, 1'b1},
    '{1'b1, 14'd0, 15'd0, 15'd0, 15'd0, 15'd0, 4'd0, 4'd0, 4'd0,
      7'd0,  7'd0,  8'd55, 1'b0, 1'b0},
    '{1'b1, 14'd0, 15'd0, 15'd0, 15'd0, 15'd0, 4'd0, 4'd0, 4'd0,
      7'd64, 7'd0,  8'd55, 1'b0, 1'b0},
    '{1'b1, 14'd0, 15'd0, 15'd0, 15'd0, 15'd0, 4'd0, 4'd0, 4'd0,
      7'd0,  7'd64, 8'd55, 1'b1, 1'b0},
    '{1'b1, 14'd0, 15'd0, 15'd0, 15'd0, 15'd0, 4'd0, 4'd0, 4'd0,
      7'd23, 7'd23, 8'd55, 1'b0, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               echo_seen = 1'b0;
  logic [PULSE_W-1:0] pulse_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               vehicle_present;
  logic               reading_valid;
  logic [DIST_W-1:0]  distance_q8;
  logic [2:0]         valid_samples;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [DIST_W-1:0]  cfg_data = '0;

  // typed expectation travels with the word it belongs to
  logic               tag_typed = 1'b0;
  round_word_t        tag_want = '0;

  echo_median_presence_qualifier #(
    .SAMPLES_PER_ROUND(ROUND)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .echo_seen       (echo_seen),
    .pulse_us        (pulse_us),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .vehicle_present (vehicle_present),
    .reading_valid   (reading_valid),
    .distance_q8     (distance_q8),
    .valid_samples   (valid_samples),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of the settings
  logic [PULSE_W-1:0] lim_timeout = TIMEOUT_RST;
  logic [DIST_W-1:0]  lim_min     = MIN_DIST_RST;
  logic [DIST_W-1:0]  lim_max     = MAX_DIST_RST;
  deb_cfg_t           deb = '{DETECT_DIST_RST, RELEASE_DIST_RST, DETECT_RNDS_RST,
                              RELEASE_RNDS_RST, INVALID_LIM_RST};

  // Predictor state
  logic [DIST_W-1:0]  held_dist [ROUND];
  logic [2:0]         slot = '0;
  logic [2:0]         n_good = '0;
  logic [RND_W-1:0]   near_cnt = '0;
  logic [RND_W-1:0]   far_cnt = '0;
  logic [RND_W-1:0]   blank_cnt = '0;
  logic               present = 1'b0;

  round_word_t        round_q [$];
  int                 errors = 0;
  int                 words_out = 0;
  int                 items_sent = 0;
  bit                 mood_near = 1'b1;
  int                 tx_idle_pct = 0;
  int                 rx_stall_pct = 0;
  int                 hold_asks = 0;
  int                 hold_served = 0;
  int                 hold_left = 0;
  int                 idle_cycles = 0;

  task automatic flag_mismatch(input string field, input logic [DIST_W-1:0] got,
                               input logic [DIST_W-1:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t: round word %0d, %s: got %0d, want %0d", $time, words_out, field, got, want);
  endtask

  // Fold one echo word into the round; returns 1 with the result when the round ends
  function automatic bit fold_echo(input logic seen, input logic [PULSE_W-1:0] pulse,
                                   output round_word_t res);
    logic [PROD_W-1:0] prod;
    logic [16:0]       dist_full;
    logic [DIST_W-1:0] srt [ROUND];
    logic [DIST_W-1:0] tmp;
    logic [DIST_W-1:0] med;
    int                n;
    prod      = PROD_W'(pulse) * PROD_W'(DIST_MUL);
    dist_full = 17'(prod >> DIST_SHIFT);
    res       = BLANK_ROUND;
    if (seen && pulse != 0 && pulse <= lim_timeout && dist_full >= lim_min &&
        dist_full <= lim_max && n_good < ROUND) begin
      held_dist[n_good] = dist_full[DIST_W-1:0];
      n_good++;
    end
    slot++;
    if (slot < ROUND) return 1'b0;

    n   = int'(n_good);
    med = '0;
    if (n > 0) begin
      // median of the valid samples, upper middle on an even count
      srt = held_dist;
      for (int i = 0; i + 1 < n; i++)
        for (int j = i + 1; j < n; j++)
          if (srt[j] < srt[i]) begin
            tmp = srt[i]; srt[i] = srt[j]; srt[j] = tmp;
          end
      med = srt[n / 2];
      blank_cnt = '0;
      if (!present) begin
        far_cnt = '0;
        if (med < deb.detect_dist) begin
          near_cnt = near_cnt + 1'b1;
          if (near_cnt >= deb.detect_rounds) begin
            present  = 1'b1;
            near_cnt = '0;
          end
        end else begin
          near_cnt = '0;
        end
      end else begin
        near_cnt = '0;
        if (med >= deb.release_dist) begin
          far_cnt = far_cnt + 1'b1;
          if (far_cnt >= deb.release_rounds) begin
            present = 1'b0;
            far_cnt = '0;
          end
        end else begin
          far_cnt = '0;
        end
      end
    end else begin
      // invalid round: saturating count forces release at the limit
      blank_cnt = blank_cnt + 1'b1;
      near_cnt  = '0;
      if (blank_cnt >= deb.invalid_limit) begin
        blank_cnt = deb.invalid_limit;
        far_cnt   = '0;
        present   = 1'b0;
      end
    end
    res = '{present, n > 0, med, n_good};
    slot   = '0;
    n_good = '0;
    return 1'b1;
  endfunction

  // Check result words, then predict from accepted echo words
  always @(posedge clk) begin
    round_word_t got;
    round_word_t want;
    round_word_t calc;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{vehicle_present, reading_valid, distance_q8, valid_samples};
        words_out++;
        if (round_q.size() == 0) begin
          flag_mismatch("word with nothing expected", DIST_W'(1), DIST_W'(0));
        end else begin
          want = round_q.pop_front();
          if (got.present !== want.present)
            flag_mismatch("vehicle_present", DIST_W'(got.present), DIST_W'(want.present));
          if (got.rvalid !== want.rvalid)
            flag_mismatch("reading_valid", DIST_W'(got.rvalid), DIST_W'(want.rvalid));
          if (got.dist_q8 !== want.dist_q8)
            flag_mismatch("distance_q8", got.dist_q8, want.dist_q8);
          if (got.nsamp !== want.nsamp)
            flag_mismatch("valid_samples", DIST_W'(got.nsamp), DIST_W'(want.nsamp));
        end
      end
      if (in_valid && !in_stall) begin
        if (fold_echo(echo_seen, pulse_us, calc))
          round_q.push_back(tag_typed ? tag_want : calc);
      end
    end
  end

  // Receiver: random stall, or a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("echo_median_presence_qualifier: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one echo word and hold it until taken
  task automatic send_word(input logic seen, input logic [PULSE_W-1:0] pulse,
                           input logic typed, input round_word_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    echo_seen <= seen;
    pulse_us  <= pulse;
    tag_typed <= typed;
    tag_want  <= want;
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_rounds_out();
    in_valid <= 1'b0;
    @(posedge clk);
    while (round_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DIST_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_TIMEOUT:      lim_timeout = data[PULSE_W-1:0];
      REG_MIN_DIST:     lim_min = data;
      REG_MAX_DIST:     lim_max = data;
      REG_DETECT_DIST:  deb.detect_dist = data;
      REG_RELEASE_DIST: deb.release_dist = data;
      REG_DETECT_RNDS:  deb.detect_rounds = data[RND_W-1:0];
      REG_RELEASE_RNDS: deb.release_rounds = data[RND_W-1:0];
      REG_INVALID_LIM:  deb.invalid_limit = data[RND_W-1:0];
      default: ;
    endcase
  endtask

  // junk fills the bits above each narrower register
  task automatic load_settings(input phase_t p, input logic [10:0] junk);
    write_reg(REG_TIMEOUT, {junk[0], p.tmo});
    write_reg(REG_MIN_DIST, p.dmin);
    write_reg(REG_MAX_DIST, p.dmax);
    write_reg(REG_DETECT_DIST, p.ddet);
    write_reg(REG_RELEASE_DIST, p.drel);
    write_reg(REG_DETECT_RNDS, {junk, p.nd});
    write_reg(REG_RELEASE_RNDS, {junk, p.nr});
    write_reg(REG_INVALID_LIM, {junk, p.nl});
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed echoes aimed at the near or far band, runs of rounds alike
  task automatic pick_echo(output logic seen, output logic [PULSE_W-1:0] pulse);
    int r;
    int target;
    if (items_sent % ROUND == 0 && $urandom_range(0, 99) < 30) mood_near = !mood_near;
    r    = $urandom_range(0, 99);
    seen = 1'b1;
    if (r < 8) begin
      seen  = 1'b0;
      pulse = 14'($urandom);
    end else if (r < 16) begin
      pulse = 14'($urandom);
    end else if (r < 22) begin
      case ($urandom_range(0, 3))
        0:       pulse = '0;
        1:       pulse = '1;
        2:       pulse = lim_timeout;
        default: pulse = lim_timeout + 1'b1;
      endcase
    end else begin
      if (mood_near) target = $urandom_range(int'(lim_min), int'(deb.detect_dist));
      else target = $urandom_range(int'(deb.release_dist), int'(lim_max));
      pulse = 14'(target * 256 / 1124 + $urandom_range(0, 1));
    end
  endtask

  initial begin
    phase_t             ph;
    logic               seen;
    logic [PULSE_W-1:0] pulse;
    logic [10:0]        junk;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rows under reset settings
    foreach (DIR_ROWS[i])
      send_word(DIR_ROWS[i].seen, DIR_ROWS[i].pulse, DIR_ROWS[i].typed, DIR_ROWS[i].want);

    foreach (PHASES[p]) begin
      wait_rounds_out();
      repeat (SETTLE) @(posedge clk);
      ph   = PHASES[p];
      junk = '0;
      if (ph.rnd) begin
        ph.tmo  = PULSE_W'($urandom_range(2000, 16383));
        ph.dmin = DIST_W'($urandom_range(0, 1500));
        ph.dmax = DIST_W'($urandom_range(9000, 32767));
        ph.ddet = DIST_W'($urandom_range(1000, 8000));
        ph.drel = ph.ddet + 15'($urandom_range(0, 3000));
        ph.nd   = RND_W'($urandom_range(1, 4));
        ph.nr   = RND_W'($urandom_range(1, 4));
        ph.nl   = RND_W'($urandom_range(1, 6));
        junk    = 11'($urandom);
      end
      load_settings(ph, junk);
      tx_idle_pct  = int'(ph.tx);
      rx_stall_pct = int'(ph.rx);
      if (ph.hold) hold_asks++;
      for (int i = 0; i < ph.n; i++) begin
        if (ph.pause && i == ph.n / 2) wait_rounds_out();
        pick_echo(seen, pulse);
        send_word(seen, pulse, 1'b0, BLANK_ROUND);
      end
    end

    wait_rounds_out();
    repeat (TAIL) @(posedge clk);
    if (errors == 0)
      $display("echo_median_presence_qualifier: match");
    else
      $display("echo_median_presence_qualifier: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
src/empq_pkg.sv
src/empq_qualify.sv
src/empq_median.sv
src/empq_debounce.sv
src/echo_median_presence_qualifier.sv
dv/tb.sv
